[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a result in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Checks that a condition implies a result in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

[rtl/tcvi_pkg.sv]
package tcvi_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int TAB_LEN = 24;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [20:0] GRAV_Q16 = 21'sd642908;

    typedef enum logic [3:0] {
        T_IDLE,
        T_CORDIC,
        T_MUL_Y,
        T_MUL_Z,
        T_Q8_X,
        T_Q8_Y,
        T_Q8_Z,
        T_VEL_X,
        T_VEL_Y,
        T_DIV,
        T_ACC,
        T_OUT
    } t_state;

    function automatic logic signed [31:0] atan_val(input logic [4:0] i);
        case (i)
            5'd0:  atan_val = 32'sh20000000;
            5'd1:  atan_val = 32'sh12E4051E;
            5'd2:  atan_val = 32'sh09FB385B;
            5'd3:  atan_val = 32'sh051111D4;
            5'd4:  atan_val = 32'sh028B0D43;
            5'd5:  atan_val = 32'sh0145D7E1;
            5'd6:  atan_val = 32'sh00A2F61E;
            5'd7:  atan_val = 32'sh00517C55;
            5'd8:  atan_val = 32'sh0028BE53;
            5'd9:  atan_val = 32'sh00145F2F;
            5'd10: atan_val = 32'sh000A2F98;
            5'd11: atan_val = 32'sh000517CC;
            5'd12: atan_val = 32'sh00028BE6;
            5'd13: atan_val = 32'sh000145F3;
            5'd14: atan_val = 32'sh0000A2FA;
            5'd15: atan_val = 32'sh0000517D;
            5'd16: atan_val = 32'sh000028BE;
            5'd17: atan_val = 32'sh0000145F;
            5'd18: atan_val = 32'sh00000A30;
            5'd19: atan_val = 32'sh00000518;
            5'd20: atan_val = 32'sh0000028C;
            5'd21: atan_val = 32'sh00000146;
            5'd22: atan_val = 32'sh000000A3;
            5'd23: atan_val = 32'sh00000051;
            default: atan_val = 32'sh0;
        endcase
    endfunction

endpackage

[rtl/tilt_compensated_velocity_integrator.sv]
// Channel   Direction  tdata fields (lowest bit up)
// s_axis    in         accel_x_raw, accel_y_raw, accel_z_raw, roll_raw, pitch_raw,
//                      time_step_us (96 bits)
// m_axis    out        lin_acc_x, lin_acc_y, lin_acc_z, vel_x, vel_y (120 bits)
// One sample takes TRIG_ITERATIONS CORDIC steps, capped at TAB_LEN (roll and pitch
// side by side), then T_MUL_Y to T_VEL_Y and T_DIV share one multiplier, T_DIV and
// T_ACC run for x then y, and T_OUT loads the output register before T_IDLE.
// Reset is synchronous, active low, and clears both velocities.
// The input is not ready while a sample is in work; a finished sample waits in
// its last cycle while the output register still holds an untaken beat.
`include "assert_macros.svh"

module tilt_compensated_velocity_integrator
    import tcvi_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, roll_raw, pitch_raw, time_step_us
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // lin_acc_x, lin_acc_y, lin_acc_z, vel_x, vel_y, zero fill
    output logic [119:0] m_axis_tdata
);

    localparam int NIT = (TRIG_ITERATIONS > TAB_LEN) ? TAB_LEN : TRIG_ITERATIONS;
    localparam logic [4:0] LAST_IT = 5'(NIT - 1);
    // Division by 100000 is a shift by five and a multiply by the reciprocal of
    // 3125, which is exact for every dividend below 2^35.
    localparam logic signed [35:0] RECIP_3125 = 36'sd22517998137;
    localparam logic signed [41:0] ROUND_HALF = 42'sd50000;

    t_state r_state, n_state;
    logic [4:0]  r_it;
    logic signed [33:0] r_xr, r_yr, r_xp, r_yp;
    logic signed [31:0] r_zr, r_zp;
    logic        r_fr, r_fp;
    logic signed [15:0] r_ax, r_ay, r_az;
    logic [15:0] r_t;
    logic signed [35:0] r_gx, r_gy, r_gz;
    logic signed [16:0] r_lx, r_ly, r_lz;
    logic signed [31:0] r_vx, r_vy;
    logic signed [41:0] r_px, r_py;
    logic        r_sel;
    logic [35:0] r_num;
    logic [31:0] r_quo;
    logic        r_neg;
    logic        r_ovalid;
    logic [114:0] r_out;

    function automatic logic signed [33:0] fold(input logic signed [15:0] a,
                                                 output logic flip);
        logic signed [16:0] b;
        begin
            b = 17'(a);
            flip = 1'b0;
            if (a >= 16'sd16384) begin
                b = b - 17'sd32768;
                flip = 1'b1;
            end else if (a < -16'sd16384) begin
                b = b + 17'sd32768;
                flip = 1'b1;
            end
            fold = 34'(b) <<< 16;
        end
    endfunction

    // Shared multiplier operands.
    logic signed [35:0] m_a;
    logic signed [35:0] m_b;
    logic signed [71:0] m_p;
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            T_MUL_Y: begin m_a = 36'(r_fr ? -r_yr : r_yr); m_b = 36'(r_fp ? -r_xp : r_xp); end
            T_MUL_Z: begin m_a = 36'(r_fp ? -r_xp : r_xp); m_b = 36'(r_fr ? -r_xr : r_xr); end
            T_Q8_X:  begin m_a = r_gx; m_b = 36'(GRAV_Q16); end
            T_Q8_Y:  begin m_a = r_gy; m_b = 36'(GRAV_Q16); end
            T_Q8_Z:  begin m_a = r_gz; m_b = 36'(GRAV_Q16); end
            T_VEL_X: begin m_a = 36'(r_lx); m_b = 36'($signed({1'b0, r_t})); end
            T_VEL_Y: begin m_a = 36'(r_ly); m_b = 36'($signed({1'b0, r_t})); end
            T_DIV:   begin m_a = $signed(r_num); m_b = RECIP_3125; end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end
    assign m_p = m_a * m_b;

    function automatic logic signed [16:0] sat17(input logic signed [71:0] p);
        logic signed [71:0] r;
        begin
            r = (p + (72'sd1 <<< 37)) >>> 38;
            if (r > 72'sd65535) sat17 = 17'sd65535;
            else if (r < -72'sd65536) sat17 = -17'sd65536;
            else sat17 = r[16:0];
        end
    endfunction

    logic signed [31:0] at;
    logic signed [32:0] acc_sum;
    logic signed [31:0] acc_sel;
    logic signed [32:0] inc;
    logic signed [33:0] f_r, f_p;
    logic fl_r, fl_p;
    assign at = atan_val(r_it);
    assign acc_sel = r_sel ? r_vy : r_vx;
    assign inc = r_neg ? -$signed({1'b0, r_quo[31:0]}) : $signed({1'b0, r_quo[31:0]});
    assign acc_sum = 33'(acc_sel) + inc;
    always_comb begin
        f_r = fold($signed(s_axis_tdata[63:48]), fl_r);
        f_p = fold($signed(s_axis_tdata[79:64]), fl_p);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE:   if (s_axis_tvalid && s_axis_tready) n_state = T_CORDIC;
            T_CORDIC: if (r_it == LAST_IT) n_state = T_MUL_Y;
            T_MUL_Y:  n_state = T_MUL_Z;
            T_MUL_Z:  n_state = T_Q8_X;
            T_Q8_X:   n_state = T_Q8_Y;
            T_Q8_Y:   n_state = T_Q8_Z;
            T_Q8_Z:   n_state = T_VEL_X;
            T_VEL_X:  n_state = T_VEL_Y;
            T_VEL_Y:  n_state = T_DIV;
            T_DIV:    n_state = T_ACC;
            T_ACC:    n_state = r_sel ? T_OUT : T_DIV;
            T_OUT:    if (!r_ovalid || m_axis_tready) n_state = T_IDLE;
            default:  n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_vx     <= '0;
            r_vy     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == T_OUT && n_state == T_IDLE) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == T_ACC) begin
                if (acc_sum > 33'sd2147483647) begin
                    if (r_sel) r_vy <= 32'sh7FFFFFFF; else r_vx <= 32'sh7FFFFFFF;
                end else if (acc_sum < -33'sd2147483648) begin
                    if (r_sel) r_vy <= 32'sh80000000; else r_vx <= 32'sh80000000;
                end else begin
                    if (r_sel) r_vy <= acc_sum[31:0]; else r_vx <= acc_sum[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            T_IDLE: begin
                r_it <= '0;
                r_ax <= $signed(s_axis_tdata[15:0]);
                r_ay <= $signed(s_axis_tdata[31:16]);
                r_az <= $signed(s_axis_tdata[47:32]);
                r_t  <= s_axis_tdata[95:80];
                r_xr <= CORDIC_X0; r_yr <= '0; r_zr <= f_r[31:0]; r_fr <= fl_r;
                r_xp <= CORDIC_X0; r_yp <= '0; r_zp <= f_p[31:0]; r_fp <= fl_p;
            end
            T_CORDIC: begin
                r_it <= r_it + 5'd1;
                if (r_zr >= 0) begin
                    r_xr <= r_xr - (r_yr >>> r_it); r_yr <= r_yr + (r_xr >>> r_it);
                    r_zr <= r_zr - at;
                end else begin
                    r_xr <= r_xr + (r_yr >>> r_it); r_yr <= r_yr - (r_xr >>> r_it);
                    r_zr <= r_zr + at;
                end
                if (r_zp >= 0) begin
                    r_xp <= r_xp - (r_yp >>> r_it); r_yp <= r_yp + (r_xp >>> r_it);
                    r_zp <= r_zp - at;
                end else begin
                    r_xp <= r_xp + (r_yp >>> r_it); r_yp <= r_yp - (r_xp >>> r_it);
                    r_zp <= r_zp + at;
                end
            end
            T_MUL_Y: begin
                r_gy <= (36'(r_ay) <<< 19) - 36'(m_p >>> 30);
                r_gx <= (36'(r_az) <<< 19) + 36'(r_fp ? -r_yp : r_yp);
            end
            T_MUL_Z: begin
                r_gz <= (36'(r_az) <<< 19) - 36'(m_p >>> 30);
                r_gx <= (36'(r_ax) <<< 19) + 36'(r_fp ? -r_yp : r_yp);
            end
            T_Q8_X: r_lx <= sat17(m_p);
            T_Q8_Y: r_ly <= sat17(m_p);
            T_Q8_Z: r_lz <= sat17(m_p);
            T_VEL_X: begin
                r_px <= 42'(m_p) <<< 8;
                r_sel <= 1'b0;
            end
            T_VEL_Y: begin
                r_py <= 42'(m_p) <<< 8;
                r_neg <= r_px < 0;
                r_num <= 36'((((r_px < 0) ? -r_px : r_px) + ROUND_HALF) >>> 5);
            end
            T_DIV: r_quo <= 32'(m_p[71:46]);
            T_ACC: begin
                r_sel <= 1'b1;
                r_neg <= r_py < 0;
                r_num <= 36'((((r_py < 0) ? -r_py : r_py) + ROUND_HALF) >>> 5);
            end
            T_OUT: if (!r_ovalid || m_axis_tready) r_out <= {r_vy, r_vx, r_lz, r_ly, r_lx};
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == T_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {5'b0, r_out};

    `ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, r_state != T_IDLE, !s_axis_tready)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, r_ovalid && !m_axis_tready,
                 r_ovalid && $stable(r_out))
    `ASSERT_NEXT(a_accept_start, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == T_CORDIC)

endmodule

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcvi_pkg::*;

    localparam int ITERATIONS = TRIG_ITERATIONS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam longint Q30_X0 = 64'sd652032874;
    localparam longint G_Q16 = 64'sd642908;
    localparam longint ARCTAN_Q32 [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct packed {
        logic [15:0] time_step_us;
        logic signed [15:0] pitch_raw;
        logic signed [15:0] roll_raw;
        logic signed [15:0] accel_z_raw;
        logic signed [15:0] accel_y_raw;
        logic signed [15:0] accel_x_raw;
    } t_imu_sample;

    typedef struct packed {
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [16:0] lin_acc_z;
        logic signed [16:0] lin_acc_y;
        logic signed [16:0] lin_acc_x;
    } t_motion;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // accel_x_raw, accel_y_raw, accel_z_raw, roll_raw, pitch_raw, time_step_us
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // lin_acc_x, lin_acc_y, lin_acc_z, vel_x, vel_y, zero fill
    logic [119:0] m_axis_tdata;

    t_motion     expected_motion [$];
    logic signed [31:0] model_vel_x;
    logic signed [31:0] model_vel_y;
    int          mismatch_count;
    int          quiet_cycles;
    bit          sender_gaps;
    bit          receiver_stalls;
    bit          hold_off_request;

    tilt_compensated_velocity_integrator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    function automatic void rotate_angle(input logic signed [15:0] angle,
                                         output longint sin_q30, output longint cos_q30);
        int     a;
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        a = angle;
        flip = 1'b0;
        if (a >= 16384) begin
            a -= 32768;
            flip = 1'b1;
        end else if (a < -16384) begin
            a += 32768;
            flip = 1'b1;
        end
        x = Q30_X0;
        y = 0;
        z = longint'(a) * 65536;
        for (int i = 0; i < ITERATIONS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARCTAN_Q32[i];
            end else begin
                x += dx;
                y -= dy;
                z += ARCTAN_Q32[i];
            end
        end
        sin_q30 = flip ? -y : y;
        cos_q30 = flip ? -x : x;
    endfunction

    function automatic logic signed [16:0] g_to_q8(input longint g);
        longint r;
        r = (g * G_Q16 + (64'sd1 <<< 37)) >>> 38;
        if (r > 65535) r = 65535;
        if (r < -65536) r = -65536;
        return r[16:0];
    endfunction

    function automatic logic signed [31:0] add_velocity(input logic signed [31:0] vel,
                                                        input logic signed [16:0] lin,
                                                        input logic [15:0] dt);
        longint p;
        longint q;
        longint v;
        p = longint'(lin) * longint'({1'b0, dt}) * 256;
        q = ((p < 0 ? -p : p) + 50000) / 100000;
        v = longint'(vel) + (p < 0 ? -q : q);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_motion compensate_and_integrate(input t_imu_sample s);
        t_motion m;
        longint  sin_roll;
        longint  cos_roll;
        longint  sin_pitch;
        longint  cos_pitch;
        rotate_angle(s.roll_raw, sin_roll, cos_roll);
        rotate_angle(s.pitch_raw, sin_pitch, cos_pitch);
        m.lin_acc_x = g_to_q8(longint'(s.accel_x_raw) * 524288 + sin_pitch);
        m.lin_acc_y = g_to_q8(longint'(s.accel_y_raw) * 524288
                              - ((sin_roll * cos_pitch) >>> 30));
        m.lin_acc_z = g_to_q8(longint'(s.accel_z_raw) * 524288
                              - ((cos_pitch * cos_roll) >>> 30));
        model_vel_x = add_velocity(model_vel_x, m.lin_acc_x, s.time_step_us);
        model_vel_y = add_velocity(model_vel_y, m.lin_acc_y, s.time_step_us);
        m.vel_x = model_vel_x;
        m.vel_y = model_vel_y;
        return m;
    endfunction

    task automatic send_sample(input t_imu_sample s);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_motion.push_back(compensate_and_integrate(s));
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("Mismatch in %s: got %0d, expected %0d", field, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_motion got;
        t_motion want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[114:0];
            if (expected_motion.size() == 0) begin
                report_mismatch("result beat count", 1, 0);
            end else begin
                want = expected_motion.pop_front();
                if (got.lin_acc_x !== want.lin_acc_x)
                    report_mismatch("lin_acc_x", got.lin_acc_x, want.lin_acc_x);
                if (got.lin_acc_y !== want.lin_acc_y)
                    report_mismatch("lin_acc_y", got.lin_acc_y, want.lin_acc_y);
                if (got.lin_acc_z !== want.lin_acc_z)
                    report_mismatch("lin_acc_z", got.lin_acc_z, want.lin_acc_z);
                if (got.vel_x !== want.vel_x)
                    report_mismatch("vel_x", got.vel_x, want.vel_x);
                if (got.vel_y !== want.vel_y)
                    report_mismatch("vel_y", got.vel_y, want.vel_y);
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_request = 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_imu_sample make_sample(input int ax, input int ay, input int az,
                                                input int roll, input int pitch, input int dt);
        t_imu_sample s;
        s.accel_x_raw = ax[15:0];
        s.accel_y_raw = ay[15:0];
        s.accel_z_raw = az[15:0];
        s.roll_raw = roll[15:0];
        s.pitch_raw = pitch[15:0];
        s.time_step_us = dt[15:0];
        return s;
    endfunction

    function automatic t_imu_sample random_sample();
        t_imu_sample s;
        if ($urandom_range(0, 9) < 3) begin
            s = {$urandom, $urandom, $urandom};
        end else begin
            s.accel_x_raw = $urandom_range(0, 8192) - 4096;
            s.accel_y_raw = $urandom_range(0, 8192) - 4096;
            s.accel_z_raw = $urandom_range(0, 8192) - 4096 + 2048;
            s.roll_raw = $urandom;
            s.pitch_raw = $urandom;
            s.time_step_us = $urandom_range(500, 20000);
        end
        return s;
    endfunction

    task automatic test_directed();
        send_sample(make_sample(0, 0, 2048, 0, 0, 0));
        send_sample(make_sample(32767, 32767, 32767, 0, 0, 65535));
        send_sample(make_sample(-32768, -32768, -32768, 0, 0, 65535));
        send_sample(make_sample(0, 0, 0, -32768, -32768, 1000));
        send_sample(make_sample(0, 0, 0, 32767, 32767, 1000));
        send_sample(make_sample(100, -100, 2048, 16384, 16384, 1));
        send_sample(make_sample(100, -100, 2048, -16384, -16384, 2));
        send_sample(make_sample(-5, 5, 2048, 16383, -16385, 3));
        send_sample(make_sample(-5, 5, 2048, -16385, 16383, 65535));
        send_sample(make_sample(2048, 0, 0, 8192, -8192, 10000));
        send_sample(make_sample(0, 2048, 0, -8192, 8192, 10000));
        send_sample(make_sample(1, -1, 1, 1, -1, 0));
        send_sample(make_sample(-1, 1, -1, -1, 1, 65535));
        send_sample(make_sample(32767, -32768, 0, 24576, -24576, 50000));
        send_sample(make_sample(-32768, 32767, 0, -24576, 24576, 50000));
        send_sample(make_sample(12345, -23456, 31000, 21845, -10923, 4321));
    endtask

    task automatic test_velocity_saturation();
        repeat (350) send_sample(make_sample(32767, 32767, 0, 16384, 0, 65535));
        repeat (700) send_sample(make_sample(-32768, -32768, 0, -16384, 0, 65535));
        send_sample(make_sample(-32768, -32768, 0, 0, 0, 0));
    endtask

    task automatic test_random(input int count);
        repeat (count) send_sample(random_sample());
    endtask

    task automatic test_backpressure();
        hold_off_request = 1'b1;
        repeat (6) send_sample(random_sample());
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        model_vel_x = '0;
        model_vel_y = '0;
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        hold_off_request = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_velocity_saturation();
        test_backpressure();
        test_random(380);
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        test_random(100);

        s_axis_tvalid <= 1'b0;
        while (expected_motion.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tcvi_pkg.sv
rtl/tilt_compensated_velocity_integrator.sv
sim/testbench.sv
